/* sv/hrkf_pkg.sv */
// Package for the heart rate Kalman filter: fixed-point widths, reset
// constants, the register indices, a saturation helper and the divider types. No dependencies.
package hrkf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int DT_W      = 17;
   localparam int NOISE_W   = 23;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 23;

   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROC_NOISE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_NOISE  = 2'd2;

   localparam logic [DT_W-1:0]    RESET_DT = DT_W'((4 * (64'd1 << FRAC_BITS) + 50) / 100);
   localparam logic [NOISE_W-1:0] RESET_Q  = NOISE_W'(((64'd1 << FRAC_BITS) + 50) / 100);
   localparam logic [NOISE_W-1:0] RESET_R  = NOISE_W'(4 * (64'd1 << FRAC_BITS));

   localparam logic signed [DATA_W-1:0] RESET_RATE = DATA_W'(70 * (64'd1 << FRAC_BITS));
   localparam logic signed [DATA_W-1:0] RESET_P00  = DATA_W'(100 * (64'd1 << FRAC_BITS));
   localparam logic signed [DATA_W-1:0] RESET_P11  = DATA_W'(10 * (64'd1 << FRAC_BITS));

   localparam logic signed [DATA_W-1:0] FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Saturate a 34-bit signed sum to 32 bits.
   function automatic logic signed [DATA_W-1:0] sat34(input logic signed [DATA_W+1:0] v);
      logic signed [DATA_W+1:0] hi;
      logic signed [DATA_W+1:0] lo;
      hi = (DATA_W+2)'(FX_MAX);
      lo = (DATA_W+2)'(FX_MIN);
      if (v > hi) return FX_MAX;
      if (v < lo) return FX_MIN;
      return v[DATA_W-1:0];
   endfunction

   // Divider request from the sequencer.
   typedef struct packed {
      logic                     start;
      logic signed [DATA_W-1:0] num;
      logic signed [DATA_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [DATA_W-1:0] quo;
   } div_rsp_type;

endpackage

/* sv/hrkf_if.sv */
// Valid/ready channel interface used by the request and response sides.
// Depends on nothing; payload width is a type parameter of the instance.
interface hrkf_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* sv/heart_rate_kalman_filter_unit.sv */
// Top level of the heart rate Kalman filter: sequencer, shared multiplier,
// shared adder and state. Depends on hrkf_pkg, hrkf_if and hrkf_div.
//
// One request is taken at a time. A request with a zero measurement is
// answered with the held estimate, the response being valid in the cycle
// right after the request is accepted. A nonzero request runs predict and
// update as 17 steps on one shared 32x32 multiplier with a registered
// product and one saturating adder, each step passing through a multiply
// state and an accumulate state, plus two gain divisions on the serial
// divider, each a start, 48 iterations and a wait for the done flag. The
// response sits in an output register, and the next request is taken once
// it has been accepted by the sink.
module heart_rate_kalman_filter_unit (
   input  logic                          clock,
   input  logic                          reset,
   hrkf_if.sink                          req,
   hrkf_if.source                        rsp,
   input  logic                          csr_we,
   input  logic [hrkf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hrkf_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import hrkf_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_ACC  = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_DWT  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   // Register file slots for the shared datapath.
   typedef enum logic [3:0] {
      R_X = 4'd0, R_V = 4'd1, R_P00 = 4'd2, R_P01 = 4'd3, R_P10 = 4'd4,
      R_P11 = 4'd5, R_DT = 4'd6, R_Q = 4'd7, R_R = 4'd8, R_Z = 4'd9,
      R_S = 4'd10, R_K0 = 4'd11, R_K1 = 4'd12, R_Y = 4'd13, R_A = 4'd14,
      R_ZERO = 4'd15
   } reg_type;

   // One micro-op: dst = sat(src_a +/- round(m1*m2)), or plain add or
   // subtract when use_mul is low (then m1 is the second operand).
   typedef struct packed {
      reg_type dst;
      reg_type src;
      reg_type m1;
      reg_type m2;
      logic    use_mul;
      logic    sub;
   } uop_type;

   localparam int NUM_OPS = 18;
   localparam int PC_W    = $clog2(NUM_OPS + 1);

   function automatic uop_type prog(input logic [PC_W-1:0] pc);
      case (pc)
         // predict
         5'd0:  return '{R_X,   R_X,   R_DT,  R_V,   1'b1, 1'b0};
         5'd1:  return '{R_P00, R_P00, R_DT,  R_P10, 1'b1, 1'b0}; // a00
         5'd2:  return '{R_P01, R_P01, R_DT,  R_P11, 1'b1, 1'b0}; // a01 = p01
         5'd3:  return '{R_P00, R_P00, R_DT,  R_P01, 1'b1, 1'b0};
         5'd4:  return '{R_P00, R_P00, R_Q,   R_ZERO,1'b0, 1'b0};
         5'd5:  return '{R_P10, R_P10, R_DT,  R_P11, 1'b1, 1'b0};
         5'd6:  return '{R_P11, R_P11, R_Q,   R_ZERO,1'b0, 1'b0};
         5'd7:  return '{R_S,   R_P00, R_R,   R_ZERO,1'b0, 1'b0};
         5'd8:  return '{R_Y,   R_Z,   R_X,   R_ZERO,1'b0, 1'b1};
         // gains are loaded by the divider between ops 8 and 9
         5'd9:  return '{R_X,   R_X,   R_K0,  R_Y,   1'b1, 1'b0};
         5'd10: return '{R_V,   R_V,   R_K1,  R_Y,   1'b1, 1'b0};
         5'd11: return '{R_A,   R_P00, R_K0,  R_P00, 1'b1, 1'b1}; // new p00
         5'd12: return '{R_P10, R_P10, R_K1,  R_P00, 1'b1, 1'b1};
         5'd13: return '{R_P00, R_A,   R_ZERO,R_ZERO,1'b0, 1'b0};
         5'd14: return '{R_A,   R_P01, R_K0,  R_P01, 1'b1, 1'b1};
         5'd15: return '{R_P11, R_P11, R_K1,  R_P01, 1'b1, 1'b1};
         5'd16: return '{R_P01, R_A,   R_ZERO,R_ZERO,1'b0, 1'b0};
         default: return '{R_ZERO, R_ZERO, R_ZERO, R_ZERO, 1'b0, 1'b0};
      endcase
   endfunction

   localparam logic [PC_W-1:0] PC_DIV  = PC_W'(9);
   localparam logic [PC_W-1:0] PC_LAST = PC_W'(16);

   state_type                state_ff, state_in;
   logic [PC_W-1:0]          pc_ff, pc_in;
   logic signed [DATA_W-1:0] rf_ff [16];
   logic [DT_W-1:0]          dt_ff;
   logic [NOISE_W-1:0]       q_ff, r_ff;
   logic                     upd_ff, upd_in;
   logic                     kidx_ff, kidx_in;
   logic signed [2*DATA_W-1:0] prod_ff;
   logic signed [DATA_W-1:0] rate_out_ff, trend_out_ff;

   uop_type                  op;
   logic signed [DATA_W-1:0] opa, opb, mb, msum;
   logic signed [2*DATA_W-1:0] prod_in;
   logic signed [2*DATA_W-1:0] rnd;
   logic signed [DATA_W-1:0] mres;
   logic signed [DATA_W+1:0] sum;
   logic signed [DATA_W-1:0] res;
   logic                     wr_en;
   reg_type                  wr_dst;
   logic signed [DATA_W-1:0] wr_val;
   logic [15:0]              meas;
   div_req_type              dreq;
   div_rsp_type              drsp;

   assign meas = req.payload;
   assign op   = prog(pc_ff);

   always_comb begin
      opa = rf_ff[op.m1];
      mb  = rf_ff[op.m2];
      prod_in = opa * mb;
      // round half up, arithmetic shift is a floor
      rnd = (prod_ff + $signed((2*DATA_W)'(64'd1 << (FRAC_BITS-1)))) >>> FRAC_BITS;
      if (rnd > (2*DATA_W)'(FX_MAX)) mres = FX_MAX;
      else if (rnd < (2*DATA_W)'(FX_MIN)) mres = FX_MIN;
      else mres = rnd[DATA_W-1:0];
      opb  = op.use_mul ? mres : opa;
      msum = rf_ff[op.src];
      sum  = op.sub ? (DATA_W+2)'(msum) - (DATA_W+2)'(opb)
                    : (DATA_W+2)'(msum) + (DATA_W+2)'(opb);
      res  = sat34(sum);
   end

   assign dreq.start = (state_ff == ST_DIV);
   assign dreq.num   = kidx_ff ? rf_ff[R_P10] : rf_ff[R_P00];
   assign dreq.den   = rf_ff[R_S];

   hrkf_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      upd_in   = upd_ff;
      kidx_in  = kidx_ff;
      wr_en    = 1'b0;
      wr_dst   = op.dst;
      wr_val   = res;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               pc_in  = '0;
               upd_in = (meas != '0);
               state_in = (meas != '0) ? (op.use_mul ? ST_MUL : ST_ACC) : ST_OUT;
               if (meas != '0) state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            wr_en = 1'b1;
            pc_in = pc_ff + 1'b1;
            if (pc_ff == PC_LAST) state_in = ST_OUT;
            else if (pc_ff + 1'b1 == PC_DIV) begin
               kidx_in  = 1'b0;
               state_in = ST_DIV;
            end else state_in = ST_MUL;
         end
         ST_DIV: state_in = ST_DWT;
         ST_DWT: begin
            if (drsp.done) begin
               wr_en   = 1'b1;
               wr_dst  = kidx_ff ? R_K1 : R_K0;
               wr_val  = drsp.quo;
               kidx_in = 1'b1;
               state_in = kidx_ff ? ST_MUL : ST_DIV;
            end
         end
         ST_OUT: begin
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req.ready   = (state_ff == ST_IDLE);
   assign rsp.valid   = (state_ff == ST_OUT);
   assign rsp.payload = {rate_out_ff, trend_out_ff, upd_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         upd_ff   <= 1'b0;
         kidx_ff  <= 1'b0;
         dt_ff    <= RESET_DT;
         q_ff     <= RESET_Q;
         r_ff     <= RESET_R;
         for (int i = 0; i < 16; i++) begin
            case (reg_type'(i))
               R_X:     rf_ff[i] <= RESET_RATE;
               R_P00:   rf_ff[i] <= RESET_P00;
               R_P11:   rf_ff[i] <= RESET_P11;
               default: rf_ff[i] <= '0;
            endcase
         end
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         upd_ff   <= upd_in;
         kidx_ff  <= kidx_in;
         if (csr_we) begin
            case (csr_index)
               CSR_TIME_STEP:  dt_ff <= csr_wdata[DT_W-1:0];
               CSR_PROC_NOISE: q_ff  <= csr_wdata[NOISE_W-1:0];
               CSR_MEAS_NOISE: r_ff  <= csr_wdata[NOISE_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE && req.valid) begin
            rf_ff[R_DT] <= DATA_W'(dt_ff);
            rf_ff[R_Q]  <= DATA_W'(q_ff);
            rf_ff[R_R]  <= DATA_W'(r_ff);
            rf_ff[R_Z]  <= DATA_W'({meas, {(FRAC_BITS-8){1'b0}}});
         end
         if (wr_en && wr_dst != R_ZERO) rf_ff[wr_dst] <= wr_val;
      end
      prod_ff <= prod_in;
      if (state_in == ST_OUT && state_ff != ST_OUT) begin
         rate_out_ff  <= (wr_en && wr_dst == R_X) ? wr_val : rf_ff[R_X];
         trend_out_ff <= (wr_en && wr_dst == R_V) ? wr_val : rf_ff[R_V];
      end
   end
endmodule

/* sv/hrkf_div.sv */
// Restoring radix-2 divider for the Kalman gain: (num << FRAC_BITS) / den,
// truncated toward zero and saturated. Depends on hrkf_pkg.
module hrkf_div (
   input  logic                 clock,
   input  logic                 reset,
   input  hrkf_pkg::div_req_type req,
   output hrkf_pkg::div_rsp_type rsp
);
   import hrkf_pkg::*;

   localparam int NUM_W = DATA_W + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic                 busy_ff, busy_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [NUM_W:0]       rem_ff, rem_in;
   logic [DATA_W-1:0]    den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic                 zero_ff, zero_in;
   logic                 done_ff, done_in;

   logic [NUM_W:0]       trial;
   logic [NUM_W:0]       rshift;
   logic [NUM_W+1:0]     sq;
   logic [DATA_W-1:0]    anum;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      anum    = req.num[DATA_W-1] ? DATA_W'(-req.num) : req.num;
      rshift  = {rem_ff[NUM_W-1:0], quo_ff[NUM_W-1]};
      trial   = rshift - (NUM_W+1)'(den_ff);
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quo_in  = {anum, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         den_in  = req.den[DATA_W-1] ? DATA_W'(-req.den) : req.den;
         neg_in  = req.num[DATA_W-1] ^ req.den[DATA_W-1];
         zero_in = (req.den == '0);
      end else if (busy_ff) begin
         if (!trial[NUM_W]) begin
            rem_in = trial;
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rshift;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      sq = neg_ff ? -(NUM_W+2)'({1'b0, quo_ff}) : (NUM_W+2)'({1'b0, quo_ff});
      if (zero_ff) rsp.quo = '0;
      else if ($signed(sq) > $signed((NUM_W+2)'(FX_MAX))) rsp.quo = FX_MAX;
      else if ($signed(sq) < $signed(-(NUM_W+2)'(64'h80000000))) rsp.quo = FX_MIN;
      else rsp.quo = sq[DATA_W-1:0];
      rsp.done = done_ff;
   end
endmodule

/* sv/hrkf_checker.sv */
// Port-level checks for the heart rate Kalman filter top level.
// Depends on hrkf_pkg; bound to heart_rate_kalman_filter_unit below.
module hrkf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] req_meas,
   input logic        rsp_upd
);
   import hrkf_pkg::*;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");

   a_skip_flag: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_meas == 16'd0) |=> (rsp_valid && !rsp_upd))
      else $error("zero measurement not answered as skipped");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");

   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("ready right after accept");
endmodule

bind heart_rate_kalman_filter_unit hrkf_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .req_meas(req.payload), .rsp_upd(rsp.payload[0])
);

/* test/tb_heart_rate_kalman_filter_unit.sv */
// Self-checking testbench for heart_rate_kalman_filter_unit: directed and random
// requests with random stalls on both channels, checked against a local predictor.
// Depends on hrkf_pkg, hrkf_if and the unit's RTL.
module tb_heart_rate_kalman_filter_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import hrkf_pkg::*;

   typedef logic [15:0] bpm_type;

   // Result fields in the order the unit packs them.
   typedef struct packed {
      logic signed [DATA_W-1:0] filtered_rate;
      logic signed [DATA_W-1:0] rate_trend;
      logic                     was_updated;
   } estimate_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   hrkf_if #(.payload_type(bpm_type))      req_ch ();
   hrkf_if #(.payload_type(estimate_type)) rsp_ch ();

   heart_rate_kalman_filter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch.sink),
      .rsp       (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // Filter state as the predictor sees it, kept in 64 bits so that every
   // intermediate can be saturated exactly as the unit does.
   longint dt_reg, q_reg, r_reg;
   longint rate_est, trend_est, p_rr, p_rt, p_tr, p_tt;

   estimate_type expected_estimates[$];
   int  failures = 0;
   bit  calm = 1'b0;     // when set, neither side idles

   function automatic longint clip32(longint v);
      if (v > longint'(FX_MAX)) return longint'(FX_MAX);
      if (v < longint'(FX_MIN)) return longint'(FX_MIN);
      return v;
   endfunction

   // Rounded fixed-point product: add half an LSB, then floor shift.
   function automatic longint fx_times(longint a, longint b);
      longint p;
      p = a * b + (longint'(1) << (FRAC_BITS - 1));
      return clip32(p >>> FRAC_BITS);
   endfunction

   // Gain quotient, truncated toward zero; a zero divisor yields zero gain.
   function automatic longint fx_ratio(longint num, longint den);
      if (den == 0) return 0;
      return clip32((num <<< FRAC_BITS) / den);
   endfunction

   task automatic reset_filter_state();
      dt_reg = RESET_DT; q_reg = RESET_Q; r_reg = RESET_R;
      rate_est = RESET_RATE; trend_est = 0;
      p_rr = RESET_P00; p_rt = 0; p_tr = 0; p_tt = RESET_P11;
   endtask

   // Advances the filter by one measurement and returns the estimate it reports.
   function automatic estimate_type track_heart_rate(bpm_type m);
      estimate_type e;
      longint a00, a01, a10, a11, p00, p01, p10, p11, z, s, k0, k1, y;
      if (m != 0) begin
         // Predict with F = [1 dt; 0 1] and Q = q*I.
         rate_est = clip32(rate_est + fx_times(dt_reg, trend_est));
         a00 = clip32(p_rr + fx_times(dt_reg, p_tr));
         a01 = clip32(p_rt + fx_times(dt_reg, p_tt));
         a10 = p_tr;
         a11 = p_tt;
         p00 = clip32(clip32(a00 + fx_times(dt_reg, a01)) + q_reg);
         p01 = a01;
         p10 = clip32(a10 + fx_times(dt_reg, a11));
         p11 = clip32(a11 + q_reg);
         // Scalar update against the rate.
         z  = clip32(longint'(m) <<< (FRAC_BITS - 8));
         s  = clip32(p00 + r_reg);
         k0 = fx_ratio(p00, s);
         k1 = fx_ratio(p10, s);
         y  = clip32(z - rate_est);
         rate_est  = clip32(rate_est + fx_times(k0, y));
         trend_est = clip32(trend_est + fx_times(k1, y));
         p_rr = clip32(p00 - fx_times(k0, p00));
         p_rt = clip32(p01 - fx_times(k0, p01));
         p_tr = clip32(p10 - fx_times(k1, p00));
         p_tt = clip32(p11 - fx_times(k1, p01));
      end
      e.filtered_rate = rate_est[31:0];
      e.rate_trend    = trend_est[31:0];
      e.was_updated   = (m != 0);
      return e;
   endfunction

   // Sends one request, with a random gap first, and records its estimate.
   task automatic send_measurement(bpm_type m);
      while (!calm && $urandom_range(99) < 10) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= m;
      do @(posedge clock); while (!req_ch.ready);
      expected_estimates.push_back(track_heart_rate(m));
   endtask

   // Holds off new requests until every outstanding estimate has come back.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_estimates.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Writes the three filter registers back to back; the unit must be idle.
   task automatic write_settings(longint dt, longint q, longint r, bit stray = 1'b0);
      csr_we <= 1'b1;
      csr_index <= CSR_TIME_STEP;  csr_wdata <= CSR_DAT_W'(dt); @(posedge clock);
      csr_index <= CSR_PROC_NOISE; csr_wdata <= CSR_DAT_W'(q);  @(posedge clock);
      csr_index <= CSR_MEAS_NOISE; csr_wdata <= CSR_DAT_W'(r);  @(posedge clock);
      if (stray) begin
         // An index past the register list must be ignored.
         csr_index <= CSR_IDX_W'(3); csr_wdata <= '1; @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
      dt_reg = dt & 64'h1FFFF;
      q_reg  = q & 64'h7FFFFF;
      r_reg  = r & 64'h7FFFFF;
   endtask

   // Response side: random back-pressure, and a check of each accepted estimate.
   always @(posedge clock) begin
      estimate_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(99) >= 10);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_estimates.size() == 0) begin
               $error("estimate with no request outstanding: %p", rsp_ch.payload);
               failures++;
            end else begin
               want = expected_estimates.pop_front();
               if (rsp_ch.payload.filtered_rate !== want.filtered_rate) begin
                  $error("filtered_rate expected %0d got %0d",
                         want.filtered_rate, rsp_ch.payload.filtered_rate);
                  failures++;
               end
               if (rsp_ch.payload.rate_trend !== want.rate_trend) begin
                  $error("rate_trend expected %0d got %0d",
                         want.rate_trend, rsp_ch.payload.rate_trend);
                  failures++;
               end
               if (rsp_ch.payload.was_updated !== want.was_updated) begin
                  $error("was_updated expected %0d got %0d",
                         want.was_updated, rsp_ch.payload.was_updated);
                  failures++;
               end
            end
         end
      end
   end

   // Defaults after reset: missing readings, the measurement extremes and a
   // few ordinary heart rates.
   task automatic test_reset_defaults();
      send_measurement(16'd0);
      send_measurement(16'd1);
      send_measurement(16'hFFFF);
      send_measurement(16'd0);
      send_measurement(16'(72 << 8));
      send_measurement(16'(75 << 8) | 16'h80);
      send_measurement(16'h8000);
      send_measurement(16'h7FFF);
      drain();
   endtask

   // Register extremes: the largest step and noise, then a frozen model.
   task automatic test_extreme_settings();
      write_settings(65536, 6553600, 6553600, 1'b1);
      send_measurement(16'hFFFF);
      send_measurement(16'd1);
      send_measurement(16'hFFFF);
      send_measurement(16'd0);
      send_measurement(16'h5555);
      send_measurement(16'hAAAA);
      drain();
      write_settings(0, 0, 1);
      send_measurement(16'(60 << 8));
      send_measurement(16'(61 << 8));
      send_measurement(16'd0);
      send_measurement(16'hFFFF);
      drain();
      // Values beyond the stated ranges are used as written.
      write_settings(131071, 8388607, 8388607);
      send_measurement(16'(90 << 8));
      send_measurement(16'd1);
      drain();
   endtask

   // Zero measurement variance drives the rate covariance to zero, after
   // which the innovation variance itself is zero and both gains vanish.
   task automatic test_zero_innovation_variance();
      write_settings(0, 0, 0);
      send_measurement(16'(80 << 8));
      send_measurement(16'(85 << 8));
      send_measurement(16'(70 << 8));
      send_measurement(16'd0);
      send_measurement(16'(65 << 8));
      drain();
   endtask

   function automatic longint pick(longint lo, longint hi);
      case ($urandom_range(5))
         0: return lo;
         1: return hi;
         default: return lo + longint'($urandom_range(32'(hi - lo)));
      endcase
   endfunction

   // Random phases: each draws settings, then mostly plausible heart-rate
   // traces, some missing readings and some arbitrary measurements.
   task automatic test_random_traces();
      int  bpm;
      bpm_type m;
      for (int phase = 0; phase < 8; phase++) begin
         calm = (phase == 3);
         if (phase == 0) write_settings(RESET_DT, RESET_Q, RESET_R);
         else write_settings(pick(0, 65536), pick(0, 6553600), pick(1, 6553600));
         bpm = $urandom_range(200, 40);
         for (int n = 0; n < 235; n++) begin
            case ($urandom_range(9))
               0: m = 16'd0;
               1, 2: m = 16'($urandom);
               default: begin
                  bpm = bpm + $urandom_range(6) - 3;
                  if (bpm < 30) bpm = 30;
                  if (bpm > 220) bpm = 220;
                  m = 16'((bpm << 8) + $urandom_range(255));
               end
            endcase
            send_measurement(m);
         end
         drain();
      end
      calm = 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      reset_filter_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_extreme_settings();
      test_zero_innovation_variance();
      test_random_traces();
      req_ch.valid <= 1'b0;
      drain();
      repeat (200) @(posedge clock);
      if (failures == 0 && expected_estimates.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // A correct run takes well under a fifth of this.
   initial begin
      #10ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
